// ===== src/pi_sc_pkg.sv =====
// shared types, constants and register codes for the pi speed controller
`default_nettype none

package pi_sc_pkg;

    // default fixed-point shifts
    localparam int DEF_PROP_SHIFT  = 4;
    localparam int DEF_INTEG_SHIFT = 4;

    // datapath widths
    localparam int SPEED_W = 7;
    localparam int GAIN_W  = 8;
    localparam int TRIM_W  = 8;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int PROD_W  = ERR_W + GAIN_W + 1;
    localparam int FF_W    = SPEED_W + GAIN_W;
    localparam int INTEG_W = 18;
    localparam int CTL_W   = INTEG_W + 1;
    localparam int DUTY_W  = 8;
    localparam int REP_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // trim and clamp constants
    localparam int TRIM_SCALE   = 10;
    localparam int TRIM_DIV_SH  = 7;
    localparam int TGT_MIN      = 5;
    localparam int TGT_MAX      = 120;
    localparam int CTL_MAX      = 255;

    // reset values of the registers
    localparam logic [SPEED_W-1:0] RST_TARGET     = '0;
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 8'd18;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN = 8'd4;
    localparam logic               RST_USE_TRIM   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_SPEED     = 2'd0,
        REG_PROP_GAIN     = 2'd1,
        REG_INTEGRAL_GAIN = 2'd2,
        REG_USE_TRIM      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SPEED_W-1:0] meas_speed;
        logic [TRIM_W-1:0]  trim_reading;
    } in_beat_t;

    typedef struct packed {
        logic [DUTY_W-1:0]       pwm_duty;
        logic [SPEED_W-1:0]      effective_target;
        logic signed [REP_W-1:0] integrator_value;
    } out_beat_t;

    typedef struct packed {
        logic [SPEED_W-1:0] set_speed;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integral_gain;
        logic               use_trim;
    } cfg_t;

    // beat between front stage and integrator stage
    typedef struct packed {
        logic [SPEED_W-1:0]       tgt;
        logic signed [PROD_W-1:0] integ_prod;
        logic [FF_W-1:0]          ff;
    } mid_beat_t;

endpackage

`default_nettype wire

// ===== src/pi_speed_controller_antiwindup.sv =====
// top level of the pi speed controller with feedforward and anti-windup
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | in_data (measured speed, pot)
//  out     | output    | out_valid / out_ready| out_data (duty, target, integ)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
//  three register stages: input, front (trim and products), integrator/result
//  one beat per cycle while the output is not stalled; each beat passes the input, front and result registers in turn
//  the integrator loop closes within the last stage, so beats follow back to back
//  each stage moves when the stage after it is empty or moving; a stalled
//  output fills the stages one by one before in_ready drops
//  reset clears valid bits and integrator and loads the configuration registers with their defaults
`default_nettype none

module pi_speed_controller_antiwindup #(
    parameter int PROP_SHIFT  = pi_sc_pkg::DEF_PROP_SHIFT,
    parameter int INTEG_SHIFT = pi_sc_pkg::DEF_INTEG_SHIFT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire pi_sc_pkg::in_beat_t               in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output pi_sc_pkg::out_beat_t                   out_data,
    input  wire logic                              cfg_we,
    input  wire logic [pi_sc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pi_sc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pi_sc_pkg::*;

    cfg_t                      cfg_reg;
    in_beat_t                  in_reg;
    logic                      in_v_reg;
    logic                      mid_v_reg;
    logic                      out_v_reg;
    logic                      in_adv;
    logic                      mid_adv;
    logic                      out_adv;
    logic                      mid_load;
    logic                      out_load;
    mid_beat_t                 mid;
    logic signed [INTEG_W-1:0] integ;

    // stage advance chain
    assign out_adv  = !out_v_reg || out_ready;
    assign mid_adv  = !mid_v_reg || out_adv;
    assign in_adv   = !in_v_reg || mid_adv;
    assign mid_load = in_v_reg && mid_adv;
    assign out_load = mid_v_reg && out_adv;

    assign in_ready  = in_adv;
    assign out_valid = out_v_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_speed     <= RST_TARGET;
            cfg_reg.prop_gain     <= RST_PROP_GAIN;
            cfg_reg.integral_gain <= RST_INTEG_GAIN;
            cfg_reg.use_trim      <= RST_USE_TRIM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SET_SPEED:     cfg_reg.set_speed     <= cfg_data[SPEED_W-1:0];
                REG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_GAIN: cfg_reg.integral_gain <= cfg_data[GAIN_W-1:0];
                REG_USE_TRIM:      cfg_reg.use_trim      <= cfg_data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_v_reg <= in_valid;
            end
            if (mid_adv)
            begin
                mid_v_reg <= in_v_reg;
            end
            if (out_adv)
            begin
                out_v_reg <= mid_v_reg;
            end
        end
    end

    // input beat register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_adv)
        begin
            in_reg <= in_data;
        end
    end

    pi_sc_front #(
        .PROP_SHIFT (PROP_SHIFT)
    ) u_front (
        .clk  (clk),
        .load (mid_load),
        .beat (in_reg),
        .cfg  (cfg_reg),
        .mid  (mid)
    );

    pi_sc_integ #(
        .INTEG_SHIFT (INTEG_SHIFT)
    ) u_integ (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (out_load),
        .mid    (mid),
        .result (out_data),
        .integ  (integ)
    );

    // in_ready low only when every stage holds a beat
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_v_reg && mid_v_reg && out_v_reg))
        else $error("input blocked with an empty stage");

    // trimmed target stays inside its clamp range
    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg_reg.use_trim) |->
        (out_data.effective_target >= SPEED_W'(TGT_MIN) &&
         out_data.effective_target <= SPEED_W'(TGT_MAX)))
        else $error("effective target outside clamp range");

    // reported integrator matches the stored one when in 16-bit range
    a_integ_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (integ[INTEG_W-1:REP_W-1] == '0 || integ[INTEG_W-1:REP_W-1] == '1))
        |-> (out_data.integrator_value == integ[REP_W-1:0]))
        else $error("reported integrator differs from integrator state");

    // integrator changes only when a result is loaded
    a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(integ))
        else $error("integrator changed without a result beat");

endmodule

`default_nettype wire

// ===== src/pi_sc_front.sv =====
// front stage: trimmed target, integral product and feedforward term
`default_nettype none

module pi_sc_front #(
    parameter int PROP_SHIFT = pi_sc_pkg::DEF_PROP_SHIFT
) (
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire pi_sc_pkg::in_beat_t  beat,
    input  wire pi_sc_pkg::cfg_t      cfg,
    output pi_sc_pkg::mid_beat_t      mid
);
    import pi_sc_pkg::*;

    localparam int D10_W = TRIM_W + 4;
    localparam int Q_W   = D10_W - TRIM_DIV_SH;
    localparam int TS_W  = SPEED_W + 2;

    logic signed [TRIM_W-1:0] trim_off;
    logic signed [D10_W-1:0]  trim_scaled;
    logic signed [D10_W-1:0]  trim_round;
    logic signed [Q_W-1:0]    trim_q;
    logic signed [TS_W-1:0]   tgt_sum;
    logic [SPEED_W-1:0]       tgt;
    logic signed [ERR_W-1:0]  err;
    mid_beat_t                mid_reg;
    mid_beat_t                mid_next;

    // pot minus center, scaled, divided by 128 toward zero
    always_comb
    begin
        trim_off    = signed'({~beat.trim_reading[TRIM_W-1], beat.trim_reading[TRIM_W-2:0]});
        trim_scaled = D10_W'(trim_off) * D10_W'(TRIM_SCALE);
        trim_round  = trim_scaled[D10_W-1]
                    ? trim_scaled + D10_W'((1 << TRIM_DIV_SH) - 1) : trim_scaled;
        trim_q      = Q_W'(trim_round >>> TRIM_DIV_SH);
        tgt_sum     = signed'(TS_W'({2'b00, cfg.set_speed})) + TS_W'(trim_q);
    end

    // target clamp when trim is on
    always_comb
    begin
        priority if (!cfg.use_trim)
        begin
            tgt = cfg.set_speed;
        end
        else if (tgt_sum < TS_W'(TGT_MIN))
        begin
            tgt = SPEED_W'(TGT_MIN);
        end
        else if (tgt_sum > TS_W'(TGT_MAX))
        begin
            tgt = SPEED_W'(TGT_MAX);
        end
        else
        begin
            tgt = tgt_sum[SPEED_W-1:0];
        end
    end

    // error times integral gain, target times prop_gain for the feedforward term
    always_comb
    begin
        err                 = signed'({1'b0, tgt}) - signed'({1'b0, beat.meas_speed});
        mid_next.tgt        = tgt;
        mid_next.integ_prod = PROD_W'(err) * signed'(PROD_W'({1'b0, cfg.integral_gain}));
        mid_next.ff         = (FF_W'(tgt) * FF_W'(cfg.prop_gain)) >> PROP_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

`default_nettype wire

// ===== src/pi_sc_integ.sv =====
// integrator stage: accumulate, output clamp, anti-windup and result register
`default_nettype none

module pi_sc_integ #(
    parameter int INTEG_SHIFT = pi_sc_pkg::DEF_INTEG_SHIFT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire pi_sc_pkg::mid_beat_t  mid,
    output pi_sc_pkg::out_beat_t       result,
    output logic signed [pi_sc_pkg::INTEG_W-1:0] integ
);
    import pi_sc_pkg::*;

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [INTEG_W-1:0] integ_sum;
    logic signed [INTEG_W-1:0] integ_shr;
    logic signed [CTL_W-1:0]   ctl;
    logic signed [CTL_W-1:0]   ctl_clamped;
    logic signed [CTL_W-1:0]   excess;
    out_beat_t                 out_reg;
    out_beat_t                 out_next;

    // accumulate and form controller output
    always_comb
    begin
        integ_sum = integ_reg + INTEG_W'(mid.integ_prod);
        integ_shr = integ_sum >>> INTEG_SHIFT;
        ctl       = CTL_W'(integ_shr) + signed'(CTL_W'({1'b0, mid.ff}));
    end

    // clamp to duty range and take the excess back out of the integrator
    always_comb
    begin
        priority if (ctl[CTL_W-1])
        begin
            ctl_clamped = '0;
        end
        else if (ctl > CTL_W'(CTL_MAX))
        begin
            ctl_clamped = CTL_W'(CTL_MAX);
        end
        else
        begin
            ctl_clamped = ctl;
        end
        excess     = ctl - ctl_clamped;
        integ_next = integ_sum - (excess[INTEG_W-1:0] << INTEG_SHIFT);
    end

    // result fields, integrator saturated to 16 bits
    always_comb
    begin
        out_next.pwm_duty         = ~ctl_clamped[DUTY_W-1:0];
        out_next.effective_target = mid.tgt;
        priority if (!integ_next[INTEG_W-1] && (integ_next[INTEG_W-2:REP_W-1] != '0))
        begin
            out_next.integrator_value = {1'b0, {(REP_W-1){1'b1}}};
        end
        else if (integ_next[INTEG_W-1] && (integ_next[INTEG_W-2:REP_W-1] != '1))
        begin
            out_next.integrator_value = {1'b1, {(REP_W-1){1'b0}}};
        end
        else
        begin
            out_next.integrator_value = integ_next[REP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (load)
        begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;
    assign integ  = integ_reg;

endmodule

`default_nettype wire
